// File: hw/rtl/exp2c_pkg.sv
// ----------------------------------------------------------------------------
// exp2c_pkg
// Shared widths, constants and word types of the cubic exp2 converter.
// ----------------------------------------------------------------------------
package exp2c_pkg;

	// Field formats
	localparam int IN_W   = 24;  // log_value and log_scale width
	localparam int FRAC_W = 16;  // fraction bits of log_value and log_scale
	localparam int COEF_W = 24;  // fraction bits of the polynomial

	// Derived widths
	localparam int PROD_W = 2 * IN_W;                       // scale product
	localparam int Q_W    = PROD_W - FRAC_W;                // product at input scale
	localparam int INT_W  = IN_W - FRAC_W + 1;              // signed integer part
	localparam int EXP_W  = ((INT_W > 8) ? INT_W : 8) + 2;  // signed biased exponent
	localparam int F_W    = COEF_W + 1;                     // signed fraction
	localparam int P_W    = COEF_W + 3;                     // signed polynomial value
	localparam int MANT_W = 23;

	localparam logic [IN_W-1:0] SCALE_RESET = IN_W'(1415104);

	localparam logic signed [EXP_W-1:0] EXP_BIAS = EXP_W'(8'h7f);
	localparam logic signed [EXP_W-1:0] EXP_MIN  = EXP_W'(1);
	localparam logic signed [EXP_W-1:0] EXP_MAX  = EXP_W'(254);

	localparam logic [31:0] MAX_FINITE = 32'h7F7F_FFFF;

	// Polynomial coefficients, signed, in Q2.COEF_W
	localparam logic signed [P_W-1:0] COEF_ONE = P_W'(64'(1) << COEF_W);
	localparam logic signed [P_W-1:0] COEF_TWO = P_W'(64'(2) << COEF_W);
	localparam logic signed [P_W-1:0] COEF_C1  = P_W'(64'(2811) << (COEF_W - 12));
	localparam logic signed [P_W-1:0] COEF_C2  = P_W'(64'(4175) << (COEF_W - 14));
	localparam logic signed [P_W-1:0] COEF_C3  = P_W'(64'(965) << (COEF_W - 14));

	typedef struct packed {
		logic signed [IN_W-1:0] log_value;
		logic                   last_in;
	} in_word_t;

	typedef struct packed {
		logic [31:0] linear_bits;
		logic        overflowed;
		logic        underflowed;
		logic        last_out;
	} out_word_t;

	// Control that travels with each pipeline stage
	typedef struct packed {
		logic valid;
		logic last;
	} tag_t;

endpackage

// File: hw/rtl/exp2c_scale.sv
// ----------------------------------------------------------------------------
// exp2c_scale
// Stages 1 and 2: take the magnitude of the input and multiply it by the scale.
// ----------------------------------------------------------------------------
module exp2c_scale (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [1:0]                           en,
	input  exp2c_pkg::tag_t                      tag_in,
	input  logic signed [exp2c_pkg::IN_W-1:0]    log_value,
	input  logic [exp2c_pkg::IN_W-1:0]           scale,
	output exp2c_pkg::tag_t                      tag_s1,
	output exp2c_pkg::tag_t                      tag_s2,
	output logic                                 neg_s2,
	output logic [exp2c_pkg::PROD_W-1:0]         prod_s2
);

	logic [exp2c_pkg::IN_W-1:0]   mag;
	logic [exp2c_pkg::IN_W-1:0]   mag_s1;
	logic                         neg_s1;
	logic [exp2c_pkg::PROD_W-1:0] prod;

	// The most negative input maps onto itself, which is the wanted magnitude
	assign mag  = log_value[exp2c_pkg::IN_W-1] ? exp2c_pkg::IN_W'(-log_value)
	                                           : exp2c_pkg::IN_W'(log_value);
	assign prod = exp2c_pkg::PROD_W'(mag_s1) * exp2c_pkg::PROD_W'(scale);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			if (en[0]) tag_s1 <= tag_in;
			if (en[1]) tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			mag_s1 <= mag;
			neg_s1 <= log_value[exp2c_pkg::IN_W-1];
		end
		if (en[1]) begin
			prod_s2 <= prod;
			neg_s2  <= neg_s1;
		end
	end

endmodule

// File: hw/rtl/exp2c_split.sv
// ----------------------------------------------------------------------------
// exp2c_split
// Stage 3: saturate the scaled value and split it into exponent and fraction.
// ----------------------------------------------------------------------------
module exp2c_split (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  exp2c_pkg::tag_t                       tag_in,
	input  logic                                  neg,
	input  logic [exp2c_pkg::PROD_W-1:0]          prod,
	output exp2c_pkg::tag_t                       tag_s3,
	output logic signed [exp2c_pkg::EXP_W-1:0]    exp_s3,
	output logic signed [exp2c_pkg::F_W-1:0]      frac_s3
);

	localparam int IW = exp2c_pkg::IN_W;
	localparam int FW = exp2c_pkg::FRAC_W;
	localparam int CW = exp2c_pkg::COEF_W;

	logic [exp2c_pkg::Q_W-1:0]          q_full;
	logic [IW-1:0]                      lim;
	logic [IW-1:0]                      q;
	logic [FW+CW-1:0]                   fm_wide;
	logic [exp2c_pkg::INT_W-1:0]        ip_mag;
	logic signed [exp2c_pkg::INT_W-1:0] ip;
	logic [exp2c_pkg::F_W-1:0]          f_mag;
	logic signed [exp2c_pkg::F_W-1:0]   f;

	assign q_full = prod[exp2c_pkg::PROD_W-1:FW];
	// Negative side reaches one step further than the positive side
	assign lim    = neg ? (IW'(1) << (IW - 1)) : ((IW'(1) << (IW - 1)) - IW'(1));
	assign q      = (q_full > exp2c_pkg::Q_W'(lim)) ? lim : q_full[IW-1:0];

	assign ip_mag = {1'b0, q[IW-1:FW]};
	assign ip     = neg ? -$signed(ip_mag) : $signed(ip_mag);

	// Align the fraction to the coefficient format by appending zero bits
	assign fm_wide = {q[FW-1:0], {CW{1'b0}}};
	assign f_mag   = {1'b0, fm_wide[FW+CW-1:FW]};
	assign f       = neg ? -$signed(f_mag) : $signed(f_mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
		end else if (en) begin
			tag_s3 <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			exp_s3  <= exp2c_pkg::EXP_W'(ip) + exp2c_pkg::EXP_BIAS;
			frac_s3 <= f;
		end
	end

endmodule

// File: hw/rtl/exp2c_horner.sv
// ----------------------------------------------------------------------------
// exp2c_horner
// One Horner step: coef + acc * f, the product truncated toward zero.
// ----------------------------------------------------------------------------
module exp2c_horner (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  exp2c_pkg::tag_t                       tag_in,
	input  logic signed [exp2c_pkg::P_W-1:0]      acc,
	input  logic signed [exp2c_pkg::P_W-1:0]      coef,
	input  logic signed [exp2c_pkg::F_W-1:0]      frac,
	input  logic signed [exp2c_pkg::EXP_W-1:0]    exp_in,
	output exp2c_pkg::tag_t                       tag_q,
	output logic signed [exp2c_pkg::P_W-1:0]      acc_q,
	output logic signed [exp2c_pkg::F_W-1:0]      frac_q,
	output logic signed [exp2c_pkg::EXP_W-1:0]    exp_q
);

	localparam int PW = exp2c_pkg::P_W;
	localparam int CW = exp2c_pkg::COEF_W;
	localparam int MW = PW - 1 + CW;

	logic [PW-1:0]                    a_mag;
	logic [exp2c_pkg::F_W-1:0]        b_mag;
	logic [MW-1:0]                    prod;
	logic [PW-1:0]                    r_mag;
	logic signed [PW-1:0]             term;
	logic                             neg;

	assign a_mag = acc[PW-1] ? PW'(-acc) : PW'(acc);
	assign b_mag = frac[exp2c_pkg::F_W-1] ? exp2c_pkg::F_W'(-frac) : exp2c_pkg::F_W'(frac);
	assign neg   = acc[PW-1] ^ frac[exp2c_pkg::F_W-1];

	// Sign-magnitude product so the shift truncates toward zero
	assign prod  = MW'(a_mag[PW-2:0]) * MW'(b_mag[CW-1:0]);
	assign r_mag = {1'b0, prod[MW-1:CW]};
	assign term  = neg ? -$signed(r_mag) : $signed(r_mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (en) begin
			tag_q <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q  <= coef + term;
			frac_q <= frac;
			exp_q  <= exp_in;
		end
	end

endmodule

// File: hw/rtl/exp2c_pack.sv
// ----------------------------------------------------------------------------
// exp2c_pack
// Last stage: normalize the polynomial, range-check the exponent, build the
// single-precision word.
// ----------------------------------------------------------------------------
module exp2c_pack (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  exp2c_pkg::tag_t                       tag_in,
	input  logic signed [exp2c_pkg::P_W-1:0]      poly,
	input  logic signed [exp2c_pkg::EXP_W-1:0]    exp_in,
	output exp2c_pkg::tag_t                       tag_q,
	output exp2c_pkg::out_word_t                  word_q
);

	localparam int CW = exp2c_pkg::COEF_W;
	localparam int MW = exp2c_pkg::MANT_W;

	logic signed [exp2c_pkg::P_W-1:0]   p_norm;
	logic signed [exp2c_pkg::EXP_W-1:0] e_norm;
	logic [exp2c_pkg::P_W-1:0]          frac;
	logic [CW+MW-1:0]                   m_wide;
	logic                               unf;
	logic                               ovf;
	exp2c_pkg::out_word_t               word;

	// The cubic stays within [1/2, 2) over the fraction range, so one step
	// either way normalizes it
	always_comb begin
		p_norm = poly;
		e_norm = exp_in;
		if (poly >= exp2c_pkg::COEF_TWO) begin
			p_norm = poly >>> 1;
			e_norm = exp_in + exp2c_pkg::EXP_W'(1);
		end else if (poly > '0 && poly < exp2c_pkg::COEF_ONE) begin
			p_norm = poly <<< 1;
			e_norm = exp_in - exp2c_pkg::EXP_W'(1);
		end
	end

	assign frac   = exp2c_pkg::P_W'(p_norm - exp2c_pkg::COEF_ONE);
	assign m_wide = {frac[CW-1:0], {MW{1'b0}}};

	assign unf = (p_norm <= '0) || (e_norm < exp2c_pkg::EXP_MIN);
	assign ovf = !unf && (e_norm > exp2c_pkg::EXP_MAX);

	always_comb begin
		word.overflowed  = ovf;
		word.underflowed = unf;
		word.last_out    = tag_in.last;
		if (unf) begin
			word.linear_bits = '0;
		end else if (ovf) begin
			word.linear_bits = exp2c_pkg::MAX_FINITE;
		end else begin
			word.linear_bits = {1'b0, e_norm[7:0], m_wide[CW+MW-1:CW]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (en) begin
			tag_q <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= word;
		end
	end

endmodule

// File: hw/rtl/exp2_cubic_db_to_linear.sv
// ----------------------------------------------------------------------------
// exp2_cubic_db_to_linear
// Scaled log-domain value to IEEE-754 single through a cubic exp2 fit.
// ----------------------------------------------------------------------------
// The block takes one word per clock while in_stall is low and returns one
// result word per input word, in order. The seven register stages are:
// input magnitude, scale multiply, saturate and split, three Horner
// multiply-add steps (one multiplier each), and normalize/pack into the
// output register. Each stage advances on its own, so bubbles close up and a
// stalled output does not stop the input until the pipeline is full. cfg_we
// writes log_scale; write it only while no word is in flight.
// ----------------------------------------------------------------------------
module exp2_cubic_db_to_linear (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [exp2c_pkg::IN_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  exp2c_pkg::in_word_t          in_word,
	output logic                         out_valid,
	input  logic                         out_stall,
	output exp2c_pkg::out_word_t         out_word
);

	logic [exp2c_pkg::IN_W-1:0] log_scale_q;

	exp2c_pkg::tag_t tag_in, tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7;
	logic [7:1]      en;

	logic                               neg_s2;
	logic [exp2c_pkg::PROD_W-1:0]       prod_s2;
	logic signed [exp2c_pkg::EXP_W-1:0] exp_s3, exp_s4, exp_s5, exp_s6;
	logic signed [exp2c_pkg::F_W-1:0]   frac_s3, frac_s4, frac_s5, frac_s6;
	logic signed [exp2c_pkg::P_W-1:0]   acc_s4, acc_s5, acc_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_scale_q <= exp2c_pkg::SCALE_RESET;
		end else if (cfg_we) begin
			log_scale_q <= cfg_data;
		end
	end

	// A stage loads when it is empty or its successor loads
	assign en[7] = !tag_s7.valid || !out_stall;
	assign en[6] = !tag_s6.valid || en[7];
	assign en[5] = !tag_s5.valid || en[6];
	assign en[4] = !tag_s4.valid || en[5];
	assign en[3] = !tag_s3.valid || en[4];
	assign en[2] = !tag_s2.valid || en[3];
	assign en[1] = !tag_s1.valid || en[2];

	assign in_stall     = !en[1];
	assign tag_in.valid = in_valid;
	assign tag_in.last  = in_word.last_in;

	exp2c_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en[2:1]),
		.tag_in    (tag_in),
		.log_value (in_word.log_value),
		.scale     (log_scale_q),
		.tag_s1    (tag_s1),
		.tag_s2    (tag_s2),
		.neg_s2    (neg_s2),
		.prod_s2   (prod_s2)
	);

	exp2c_split u_split (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en[3]),
		.tag_in  (tag_s2),
		.neg     (neg_s2),
		.prod    (prod_s2),
		.tag_s3  (tag_s3),
		.exp_s3  (exp_s3),
		.frac_s3 (frac_s3)
	);

	exp2c_horner u_horner_c2 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en[4]),
		.tag_in (tag_s3),
		.acc    (exp2c_pkg::COEF_C3),
		.coef   (exp2c_pkg::COEF_C2),
		.frac   (frac_s3),
		.exp_in (exp_s3),
		.tag_q  (tag_s4),
		.acc_q  (acc_s4),
		.frac_q (frac_s4),
		.exp_q  (exp_s4)
	);

	exp2c_horner u_horner_c1 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en[5]),
		.tag_in (tag_s4),
		.acc    (acc_s4),
		.coef   (exp2c_pkg::COEF_C1),
		.frac   (frac_s4),
		.exp_in (exp_s4),
		.tag_q  (tag_s5),
		.acc_q  (acc_s5),
		.frac_q (frac_s5),
		.exp_q  (exp_s5)
	);

	exp2c_horner u_horner_c0 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en[6]),
		.tag_in (tag_s5),
		.acc    (acc_s5),
		.coef   (exp2c_pkg::COEF_ONE),
		.frac   (frac_s5),
		.exp_in (exp_s5),
		.tag_q  (tag_s6),
		.acc_q  (acc_s6),
		.frac_q (frac_s6),
		.exp_q  (exp_s6)
	);

	exp2c_pack u_pack (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en[7]),
		.tag_in (tag_s6),
		.poly   (acc_s6),
		.exp_in (exp_s6),
		.tag_q  (tag_s7),
		.word_q (out_word)
	);

	// The fraction is no longer needed after the last Horner step
	logic frac_s6_unused;
	assign frac_s6_unused = ^frac_s6;

	assign out_valid = tag_s7.valid;

endmodule

// File: hw/rtl/exp2c_checker.sv
// ----------------------------------------------------------------------------
// exp2c_checker
// Port-level checks on the converter's result words.
// ----------------------------------------------------------------------------
module exp2c_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  exp2c_pkg::out_word_t out_word
);

	// Range flags are exclusive
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_word.overflowed && out_word.underflowed))
		else $error("overflow and underflow flagged together");

	// Underflow forces zero
	a_underflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.underflowed) |-> (out_word.linear_bits == 32'h0))
		else $error("underflow word is not zero");

	// Overflow clamps to the largest finite value
	a_overflow_max: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.overflowed) |->
		(out_word.linear_bits == exp2c_pkg::MAX_FINITE))
		else $error("overflow word is not the largest finite value");

	// A power of two is never negative, nor infinite or NaN
	a_positive_finite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_word.linear_bits[31] && (out_word.linear_bits[30:23] != 8'hff)))
		else $error("result word has sign set or exponent all ones");

	// Hold a stalled result word
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_word)))
		else $error("stalled result word changed or dropped");

endmodule

bind exp2_cubic_db_to_linear exp2c_checker u_exp2c_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);
